// ----- sv/tbms_pkg.sv -----
`timescale 1ns / 1ps

package tbms_pkg;

  // Field widths
  localparam int LEVEL_W = 8;
  localparam int TPL_W   = 3;
  localparam int IDX_W   = 8;
  localparam int AREA_W  = 13;
  localparam int LIMIT_W = 20;
  localparam int SQ_W    = 16;
  localparam int SUM_W   = 28;
  localparam int SCORE_W = 27;

  // The numerator is sum * 1296, which needs 11 more bits than the sum.
  localparam int NUM_W = SUM_W + 11;
  localparam int CNT_W = $clog2(NUM_W + 1);

  // Glyph queue between the front and the back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Constants
  localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_MAX   = {SCORE_W{1'b1}};
  localparam logic [SCORE_W-1:0] SURE_Q8     = SCORE_W'(256);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3072);

  // One finished glyph sum, handed from the front to the back
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [AREA_W-1:0] area;
    logic [IDX_W-1:0]  idx;
    logic              last_letter;
  } glyph_t;

  // Glyph request with its valid flag
  typedef struct packed {
    logic   valid;
    glyph_t glyph;
  } glyph_req_t;

endpackage

// ----- sv/tbms_intf.sv -----
`timescale 1ns / 1ps

// Pixel pair channel
interface tbms_pix_if;
  logic                         valid;
  logic                         ready;
  logic [tbms_pkg::LEVEL_W-1:0] image_level;
  logic [tbms_pkg::TPL_W-1:0]   template_level;
  logic [tbms_pkg::IDX_W-1:0]   letter_index;
  logic [tbms_pkg::AREA_W-1:0]  area;
  logic                         last_pixel;
  logic                         last_letter;

  modport source(output valid, image_level, template_level, letter_index, area,
                 last_pixel, last_letter, input ready);
  modport sink(input valid, image_level, template_level, letter_index, area,
               last_pixel, last_letter, output ready);
endinterface

// Best match result channel
interface tbms_res_if;
  logic                         valid;
  logic                         ready;
  logic [tbms_pkg::IDX_W-1:0]   match_letter;
  logic                         found;
  logic [tbms_pkg::SCORE_W-1:0] best_score_q8;

  modport source(output valid, match_letter, found, best_score_q8, input ready);
  modport sink(input valid, match_letter, found, best_score_q8, output ready);
endinterface

// Match limit write channel
interface tbms_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tbms_pkg::LIMIT_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- sv/tbms_front.sv -----
`timescale 1ns / 1ps

module tbms_front (
  input  logic                 clk,
  input  logic                 rst,
  tbms_pix_if.sink             pix,
  output tbms_pkg::glyph_req_t push,
  input  logic                 q_full
);

  logic [tbms_pkg::SUM_W-1:0]   sum;
  logic [tbms_pkg::SUM_W-1:0]   sum_next;
  logic [tbms_pkg::LEVEL_W-1:0] tpl_ext;
  logic [tbms_pkg::LEVEL_W-1:0] diff;
  logic [tbms_pkg::SQ_W-1:0]    sq;
  logic [tbms_pkg::SUM_W:0]     total;
  logic                         accept;

  // A pixel is taken whenever a finished glyph could still be queued.
  assign pix.ready = !q_full;
  assign accept    = pix.valid && pix.ready;

  // Absolute level difference, squared, added with saturation.
  always_comb begin
    tpl_ext = tbms_pkg::LEVEL_W'(pix.template_level);
    if (pix.image_level > tpl_ext) begin
      diff = pix.image_level - tpl_ext;
    end else begin
      diff = tpl_ext - pix.image_level;
    end
    sq    = tbms_pkg::SQ_W'(diff) * tbms_pkg::SQ_W'(diff);
    total = {1'b0, sum} + (tbms_pkg::SUM_W + 1)'(sq);
    if (total[tbms_pkg::SUM_W]) begin
      sum_next = tbms_pkg::SUM_MAX;
    end else begin
      sum_next = total[tbms_pkg::SUM_W-1:0];
    end
  end

  // The glyph sum goes to the queue on its last pixel.
  always_comb begin
    push.valid             = accept && pix.last_pixel;
    push.glyph.sum         = sum_next;
    push.glyph.area        = pix.area;
    push.glyph.idx         = pix.letter_index;
    push.glyph.last_letter = pix.last_letter;
  end

  // Running sum, cleared at each glyph end.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (accept) begin
      if (pix.last_pixel) begin
        sum <= '0;
      end else begin
        sum <= sum_next;
      end
    end
  end

endmodule

// ----- sv/tbms_queue.sv -----
`timescale 1ns / 1ps

module tbms_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  tbms_pkg::glyph_req_t push,
  output logic                 full,
  output tbms_pkg::glyph_req_t head,
  input  logic                 pop
);

  tbms_pkg::glyph_t              entries [tbms_pkg::QUEUE_DEPTH];
  logic [tbms_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tbms_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tbms_pkg::QCNT_W-1:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign full       = (count == tbms_pkg::QCNT_W'(tbms_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.glyph = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.glyph;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/tbms_back.sv -----
`timescale 1ns / 1ps

module tbms_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tbms_pkg::LIMIT_W-1:0] limit,
  input  tbms_pkg::glyph_req_t         head,
  output logic                         pop,
  tbms_res_if.source                   res
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]                   state;
  tbms_pkg::glyph_t             rec;
  logic [tbms_pkg::NUM_W-1:0]   num;
  logic [tbms_pkg::AREA_W-1:0]  rem;
  logic [tbms_pkg::CNT_W-1:0]   cnt;
  logic                         zero_area;

  logic [tbms_pkg::SCORE_W-1:0] best_score;
  logic [tbms_pkg::IDX_W-1:0]   best_index;
  logic                         have_match;
  logic                         stop_early;

  logic                         out_valid;
  logic [tbms_pkg::IDX_W-1:0]   out_letter;
  logic                         out_found;
  logic [tbms_pkg::SCORE_W-1:0] out_score;
  logic                         out_free;

  logic [tbms_pkg::AREA_W:0]    rem_shift;
  logic [tbms_pkg::AREA_W:0]    rem_sub;
  logic                         qbit;
  logic [tbms_pkg::NUM_W-1:0]   num_mul;
  logic [tbms_pkg::SCORE_W-1:0] score;
  logic                         better;

  assign out_free = !out_valid || res.ready;
  assign pop      = (state == ST_IDLE) && head.valid;

  // One restoring division step: shift in the next numerator bit.
  always_comb begin
    rem_shift = {rem, num[tbms_pkg::NUM_W-1]};
    rem_sub   = rem_shift - {1'b0, rec.area};
    qbit      = (rem_shift >= {1'b0, rec.area});
  end

  // Sum times 1296 as shifted adds: 1296 = 1024 + 256 + 16.
  always_comb begin
    num_mul = (tbms_pkg::NUM_W'(rec.sum) << 10)
            + (tbms_pkg::NUM_W'(rec.sum) << 8)
            + (tbms_pkg::NUM_W'(rec.sum) << 4);
  end

  // Saturated score and the acceptance test.
  always_comb begin
    if (zero_area || (num > tbms_pkg::NUM_W'(tbms_pkg::SCORE_MAX))) begin
      score = tbms_pkg::SCORE_MAX;
    end else begin
      score = num[tbms_pkg::SCORE_W-1:0];
    end
    better = (score < best_score) && (score < tbms_pkg::SCORE_W'(limit));
  end

  // Sequencer: take a glyph, divide, decide, and report at the last glyph.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      best_score <= tbms_pkg::SCORE_MAX;
      best_index <= '0;
      have_match <= 1'b0;
      stop_early <= 1'b0;
      zero_area  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            rec       <= head.glyph;
            zero_area <= (head.glyph.area == '0);
            if (stop_early) begin
              if (head.glyph.last_letter) begin
                state <= ST_RESULT;
              end
            end else if (head.glyph.area == '0) begin
              state <= ST_DECIDE;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          num   <= num_mul;
          rem   <= '0;
          cnt   <= tbms_pkg::CNT_W'(tbms_pkg::NUM_W);
          state <= ST_DIV;
        end
        ST_DIV: begin
          num <= {num[tbms_pkg::NUM_W-2:0], qbit};
          if (qbit) begin
            rem <= rem_sub[tbms_pkg::AREA_W-1:0];
          end else begin
            rem <= rem_shift[tbms_pkg::AREA_W-1:0];
          end
          cnt <= cnt - 1'b1;
          if (cnt == tbms_pkg::CNT_W'(1)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (better) begin
            best_score <= score;
            best_index <= rec.idx;
            have_match <= 1'b1;
          end
          if (score < tbms_pkg::SURE_Q8) begin
            stop_early <= 1'b1;
          end
          if (rec.last_letter) begin
            state <= ST_RESULT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            best_score <= tbms_pkg::SCORE_MAX;
            best_index <= '0;
            have_match <= 1'b0;
            stop_early <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_RESULT) && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESULT) && out_free) begin
      out_found  <= have_match;
      out_letter <= have_match ? best_index : '0;
      out_score  <= have_match ? best_score : '0;
    end
  end

  assign res.valid         = out_valid;
  assign res.match_letter  = out_letter;
  assign res.found         = out_found;
  assign res.best_score_q8 = out_score;

endmodule

// ----- sv/template_best_match_scorer_unit.sv -----
`timescale 1ns / 1ps

// Template best match scorer.
// The pix channel takes one pixel pair per request: the image level and the
// template level, with the glyph number, its area and the last_pixel and
// last_letter marks. The front sums squared level differences at one pixel
// per cycle while the queue has room, and queues each finished glyph sum
// (two entries deep). The back scores a glyph as floor(1296 * sum / area)
// with a bit-serial divider and keeps the lowest score below the match
// limit, ignoring later glyphs once one scores below 1.0 in Q8.
// A glyph with a nonzero area passes the back as handoff, multiply, one
// divide step per numerator bit and decision; pixel input runs at one per
// cycle until the queue fills, and then pix.ready drops. At the last glyph
// the result state loads the output register, raising the result request;
// after an early stop, glyphs only pass the handoff. The cfg channel writes
// the 20-bit match limit and is always ready; the user must write it only
// while the block is idle, which the block does not enforce.
// Reset sets the limit to 3072 (twelve in Q8) and clears all match state.
// When the receiver stalls, the result holds in the output register and the
// back waits, while the front keeps summing until the queue is full.

module template_best_match_scorer_unit (
  input logic        clk,
  input logic        rst,
  tbms_pix_if.sink   pix,
  tbms_res_if.source result,
  tbms_cfg_if.sink   cfg
);

  logic [tbms_pkg::LIMIT_W-1:0] limit;
  tbms_pkg::glyph_req_t         push;
  tbms_pkg::glyph_req_t         head;
  logic                         q_full;
  logic                         pop;

  // Match limit register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= tbms_pkg::LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      limit <= cfg.data;
    end
  end

  tbms_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pix    (pix),
    .push   (push),
    .q_full (q_full)
  );

  tbms_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  tbms_back u_back (
    .clk   (clk),
    .rst   (rst),
    .limit (limit),
    .head  (head),
    .pop   (pop),
    .res   (result)
  );

endmodule

// ----- tb/tb_template_best_match_scorer_unit.sv -----
`timescale 1ns / 1ps

module tb_template_best_match_scorer_unit;

  // Square of the level scale of 36, applied before the area division.
  localparam longint unsigned LEVEL_SCALE_SQ = 1296;
  localparam logic [tbms_pkg::LIMIT_W-1:0] LIMIT_MAX = {tbms_pkg::LIMIT_W{1'b1}};
  localparam int AREA_MAX_FIELD = (1 << tbms_pkg::AREA_W) - 1;
  // Cycles to let the back finish glyphs that produce no result.
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS = 210;
  localparam int NUM_PHASES = 7;

  typedef enum int {STYLE_EXACT, STYLE_NEAR, STYLE_FAR, STYLE_MIXED} glyph_style_t;

  typedef struct packed {
    logic [tbms_pkg::LEVEL_W-1:0] image_level;
    logic [tbms_pkg::TPL_W-1:0]   template_level;
    logic [tbms_pkg::IDX_W-1:0]   letter_index;
    logic [tbms_pkg::AREA_W-1:0]  area;
    logic                         last_pixel;
    logic                         last_letter;
  } pixel_t;

  typedef struct packed {
    logic [tbms_pkg::IDX_W-1:0]   match_letter;
    logic                         found;
    logic [tbms_pkg::SCORE_W-1:0] best_score_q8;
  } match_t;

  // Tracks the scoring state of the block and the best matches it owes.
  class best_match_predictor_t;
    longint unsigned limit_q8;
    longint unsigned diff_sum;
    longint unsigned best_score;
    logic [tbms_pkg::IDX_W-1:0] best_index;
    bit have_match;
    bit stop_early;
    match_t expected_matches[$];
    int mismatches;

    function new();
      limit_q8 = tbms_pkg::LIMIT_RESET;
      mismatches = 0;
      clear_position();
    endfunction

    function void clear_position();
      diff_sum = 0;
      best_score = tbms_pkg::SCORE_MAX;
      best_index = '0;
      have_match = 1'b0;
      stop_early = 1'b0;
    endfunction

    function void set_limit(logic [tbms_pkg::LIMIT_W-1:0] value);
      limit_q8 = value;
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction

    // Floored Q8 mean square error, saturated; zero area never matches.
    function longint unsigned glyph_score(longint unsigned sum, longint unsigned area);
      longint unsigned q;
      if (area == 0) begin
        return tbms_pkg::SCORE_MAX;
      end
      q = (sum * LEVEL_SCALE_SQ) / area;
      if (q > tbms_pkg::SCORE_MAX) begin
        q = tbms_pkg::SCORE_MAX;
      end
      return q;
    endfunction

    // Advance the state by one accepted pixel request.
    function void note_pixel(pixel_t p);
      longint unsigned d;
      longint unsigned sq;
      longint unsigned s;
      match_t m;
      if (!stop_early) begin
        if (p.image_level > p.template_level) begin
          d = p.image_level - p.template_level;
        end else begin
          d = p.template_level - p.image_level;
        end
        sq = d * d;
        if (diff_sum > longint'(tbms_pkg::SUM_MAX) - sq) begin
          diff_sum = tbms_pkg::SUM_MAX;
        end else begin
          diff_sum += sq;
        end
        if (p.last_pixel) begin
          s = glyph_score(diff_sum, p.area);
          if (s < best_score && s < limit_q8) begin
            best_score = s;
            best_index = p.letter_index;
            have_match = 1'b1;
          end
          if (s < tbms_pkg::SURE_Q8) begin
            stop_early = 1'b1;
          end
        end
      end
      if (p.last_pixel) begin
        diff_sum = 0;
      end
      if (p.last_pixel && p.last_letter) begin
        m.found = have_match;
        m.match_letter = have_match ? best_index : '0;
        m.best_score_q8 = have_match ? tbms_pkg::SCORE_W'(best_score) : '0;
        expected_matches.insert(expected_matches.size(), m);
        clear_position();
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one accepted result request with the oldest expected match.
    task check_match(logic [tbms_pkg::IDX_W-1:0] letter, logic found,
                     logic [tbms_pkg::SCORE_W-1:0] score);
      match_t want;
      if (expected_matches.size() == 0) begin
        report_mismatch($sformatf("unexpected result letter %0d found %0b score %0d",
                                  letter, found, score));
        return;
      end
      want = expected_matches[0];
      expected_matches.delete(0);
      if (letter !== want.match_letter) begin
        report_mismatch($sformatf("match_letter %0d, expected %0d", letter,
                                  want.match_letter));
      end
      if (found !== want.found) begin
        report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
      end
      if (score !== want.best_score_q8) begin
        report_mismatch($sformatf("best_score_q8 %0d, expected %0d", score,
                                  want.best_score_q8));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  tbms_pix_if pix();
  tbms_res_if result();
  tbms_cfg_if cfg();

  template_best_match_scorer_unit dut (
    .clk(clk),
    .rst(rst),
    .pix(pix),
    .result(result),
    .cfg(cfg)
  );

  best_match_predictor_t pred = new();

  int items_sent = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int stall_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result receiver: check accepted requests, stall on a random pattern that is
  // redrawn whenever its counter runs out, including stretches with no stalls.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      pred.check_match(result.match_letter, result.found, result.best_score_q8);
    end
    if (stall_count == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
      stall_count <= 255;
    end else begin
      stall_count <= stall_count - 1;
    end
    result.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic pixel_t mk_pixel(int img, int tpl, int idx, int area, bit lp, bit ll);
    pixel_t p;
    p.image_level = tbms_pkg::LEVEL_W'(img);
    p.template_level = tbms_pkg::TPL_W'(tpl);
    p.letter_index = tbms_pkg::IDX_W'(idx);
    p.area = tbms_pkg::AREA_W'(area);
    p.last_pixel = lp;
    p.last_letter = ll;
    return p;
  endfunction

  // Send one pixel request; when gap_max is set the sender sends in bursts with random idle gaps.
  task automatic send_pix(input pixel_t p);
    pix.valid <= 1'b1;
    pix.image_level <= p.image_level;
    pix.template_level <= p.template_level;
    pix.letter_index <= p.letter_index;
    pix.area <= p.area;
    pix.last_pixel <= p.last_pixel;
    pix.last_letter <= p.last_letter;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    pred.note_pixel(p);
    items_sent++;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        pix.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop sending and wait until every expected match has arrived.
  task automatic drain_results(input int settle);
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pred.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_limit(input logic [tbms_pkg::LIMIT_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    pred.set_limit(value);
    cfg.valid <= 1'b0;
  endtask

  // One glyph of pixels whose image levels follow the chosen style.
  task automatic send_glyph(input int idx, input int npix, input int area,
                            input glyph_style_t style, input bit final_letter);
    int tpl;
    int img;
    for (int i = 0; i < npix; i++) begin
      tpl = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
      case (style)
        STYLE_EXACT: img = tpl;
        STYLE_NEAR: begin
          if (tpl > 0 && $urandom_range(0, 1) == 1) begin
            img = tpl - 1;
          end else begin
            img = tpl + $urandom_range(0, 1);
          end
        end
        STYLE_FAR: img = $urandom_range(0, 255);
        default: begin
          img = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : tpl + $urandom_range(0, 1);
        end
      endcase
      send_pix(mk_pixel(img, tpl, idx, area, i == npix - 1, final_letter));
    end
  endtask

  // A well formed position: one to six glyphs, the last one marked throughout.
  task automatic send_position();
    int n_letters;
    int npix;
    int area;
    int r;
    glyph_style_t style;
    n_letters = $urandom_range(1, 6);
    for (int l = 0; l < n_letters; l++) begin
      npix = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        area = npix;
      end else if (r < 85) begin
        area = $urandom_range(0, AREA_MAX_FIELD);
      end else begin
        area = npix * $urandom_range(2, 4);
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        style = STYLE_EXACT;
      end else if (r < 60) begin
        style = STYLE_NEAR;
      end else if (r < 80) begin
        style = STYLE_FAR;
      end else begin
        style = STYLE_MIXED;
      end
      send_glyph($urandom_range(0, 255), npix, area, style, l == n_letters - 1);
    end
  endtask

  // Pixels with every field and mark random.
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_pix(mk_pixel($urandom_range(0, 255), $urandom_range(0, 7), $urandom_range(0, 255),
                        $urandom_range(0, AREA_MAX_FIELD), $urandom_range(0, 9) < 3,
                        $urandom_range(0, 9) < 3));
    end
  endtask

  task automatic run_phase(input int target);
    int start;
    int r;
    start = items_sent;
    case ($urandom_range(0, 2))
      0: gap_max = 0;
      1: gap_max = 2;
      default: gap_max = 6;
    endcase
    burst_left = 0;
    while (items_sent - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_position();
      end else if (r < 92) begin
        send_noise($urandom_range(1, 10));
      end else begin
        send_noise(1);
      end
      // Now and then hold the sender until the block has delivered everything.
      if ($urandom_range(0, 29) == 0) begin
        drain_results(0);
      end
    end
    drain_results(SETTLE_CYCLES);
  endtask

  initial begin
    logic [tbms_pkg::LIMIT_W-1:0] limit;
    pix.valid <= 1'b0;
    pix.image_level <= '0;
    pix.template_level <= '0;
    pix.letter_index <= '0;
    pix.area <= '0;
    pix.last_pixel <= 1'b0;
    pix.last_letter <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed cases at the reset limit.
    gap_max = 3;
    // A perfect single pixel glyph scores zero.
    send_pix(mk_pixel(5, 5, 3, 1, 1, 1));
    // Two equal scores keep the first glyph; a perfect one then stops scoring,
    // and the far glyph after it is ignored.
    send_pix(mk_pixel(1, 0, 7, 2, 0, 0));
    send_pix(mk_pixel(4, 5, 7, 2, 1, 0));
    send_pix(mk_pixel(2, 3, 9, 2, 0, 0));
    send_pix(mk_pixel(0, 1, 9, 2, 1, 0));
    send_pix(mk_pixel(0, 0, 11, 1, 1, 0));
    send_pix(mk_pixel(255, 0, 12, 2, 0, 1));
    send_pix(mk_pixel(200, 2, 12, 2, 1, 1));
    // Template levels six and seven with a zero area glyph.
    send_pix(mk_pixel(0, 7, 20, 0, 0, 1));
    send_pix(mk_pixel(6, 6, 20, 0, 1, 1));
    // Score overflow, then a glyph at the largest area field value.
    send_pix(mk_pixel(255, 0, 30, 1, 0, 0));
    send_pix(mk_pixel(255, 0, 30, 1, 1, 0));
    send_pix(mk_pixel(255, 7, 31, AREA_MAX_FIELD, 1, 1));
    // Last letter mark without the last pixel, then the highest glyph number.
    send_pix(mk_pixel(0, 0, 40, 4096, 0, 1));
    send_pix(mk_pixel(5, 5, 255, 4096, 1, 1));
    drain_results(SETTLE_CYCLES);

    // Random phases, each under its own match limit.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: limit = LIMIT_MAX;
        1: limit = '0;
        2: limit = tbms_pkg::LIMIT_W'(1);
        3: limit = tbms_pkg::LIMIT_W'(tbms_pkg::SURE_Q8);
        4: limit = tbms_pkg::LIMIT_RESET;
        5: limit = tbms_pkg::LIMIT_W'($urandom_range(0, 4000));
        default: limit = tbms_pkg::LIMIT_W'($urandom_range(0, LIMIT_MAX));
      endcase
      write_limit(limit);
      run_phase(PHASE_ITEMS);
    end

    if (pred.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
